### rtl/unordered_set_rotating_take_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for unordered_set_rotating_take_core
// Shorthand for clocked implication checks under the active-low reset.
// ----------------------------------------------------------------------------
`ifndef UNORDERED_SET_ROTATING_TAKE_CORE_ASSERT_SVH
`define UNORDERED_SET_ROTATING_TAKE_CORE_ASSERT_SVH

// same-cycle implication
`define USRT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("usrt: same-cycle check failed");

// next-cycle implication
`define USRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("usrt: next-cycle check failed");

`endif

### rtl/usrt_pkg.sv
// ----------------------------------------------------------------------------
// usrt_pkg
// Field widths and command codes of the unordered set core.
// ----------------------------------------------------------------------------
package usrt_pkg;

    localparam int CMD_W   = 3;
    localparam int ITEM_W  = 32;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TAKE     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

endpackage

### rtl/usrt_ram.sv
// ----------------------------------------------------------------------------
// usrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module usrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/unordered_set_rotating_take_core.sv
// ----------------------------------------------------------------------------
// unordered_set_rotating_take_core
// Fixed-capacity unordered set: append, remove, contains, rotating take and
// clear, one command at a time, over a single-port-read entry RAM.
// ----------------------------------------------------------------------------
// Command flow: append, clear and take on an empty set finish at dispatch;
// contains and remove scan the entries; a remove hit then swap-deletes; take
// reduces the pointer by repeated subtraction of the count, then swap-deletes.
// Throughput: one item at a time, busy high for the whole command; the next
// item can be accepted at the edge that takes the result.
// Reset (sync, active low) empties the set and zeroes the take pointer.
module unordered_set_rotating_take_core #(
    parameter int DEPTH     = 64,
    parameter int ITEM_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [usrt_pkg::CMD_W-1:0]   i_cmd,
    input  logic [usrt_pkg::ITEM_W-1:0]  i_item_value,
    output logic                         o_done,
    output logic                         o_ok,
    output logic [usrt_pkg::ITEM_W-1:0]  o_item_out,
    output logic [usrt_pkg::SLOT_W-1:0]  o_slot,
    output logic [usrt_pkg::COUNT_W-1:0] o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (ITEM_BITS < usrt_pkg::ITEM_W) ? ITEM_BITS : usrt_pkg::ITEM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_MOD,
        S_RD_IDX,
        S_RD_LAST,
        S_WRITE
    } t_state;

    t_state                       r_state, n_state;
    logic [usrt_pkg::CMD_W-1:0]   r_cmd, n_cmd;
    logic [IW-1:0]                r_val, n_val;
    logic [CW-1:0]                r_count, n_count;
    logic [CW-1:0]                r_ptr, n_ptr;
    logic [CW-1:0]                r_idx, n_idx;
    logic                         r_pend, n_pend;
    logic [AW-1:0]                r_slot, n_slot;
    logic [IW-1:0]                r_item, n_item;
    logic                         r_done, n_done;
    logic                         r_ok, n_ok;
    logic [IW-1:0]                r_out_item, n_out_item;
    logic [AW-1:0]                r_out_slot, n_out_slot;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [IW-1:0]                ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [IW-1:0]                ram_rdata;

    logic [CW-1:0]                last_idx;
    logic [CW-1:0]                prev_idx;
    logic [IW+usrt_pkg::ITEM_W-1:0]  item_ext;
    logic [AW+usrt_pkg::SLOT_W-1:0]  slot_ext;
    logic [CW+usrt_pkg::COUNT_W-1:0] count_ext;

    assign last_idx = r_count - 1'b1;
    assign prev_idx = r_idx - 1'b1;

    usrt_ram #(
        .WIDTH (IW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_val      = r_val;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_slot     = r_slot;
        n_item     = r_item;
        n_done     = 1'b0;
        n_ok       = r_ok;
        n_out_item = r_out_item;
        n_out_slot = r_out_slot;
        ram_we     = 1'b0;
        ram_waddr  = r_slot;
        ram_wdata  = ram_rdata;
        ram_raddr  = last_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_val   = i_item_value[IW-1:0];
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_ok       = 1'b0;
                n_out_item = '0;
                n_out_slot = '0;
                n_idx      = '0;
                n_pend     = 1'b0;
                n_state    = S_IDLE;
                case (r_cmd)
                    usrt_pkg::CMD_APPEND: begin
                        n_done = 1'b1;
                        if (r_count < CW'(DEPTH)) begin
                            ram_we     = 1'b1;
                            ram_waddr  = r_count[AW-1:0];
                            ram_wdata  = r_val;
                            n_count    = r_count + 1'b1;
                            n_ok       = 1'b1;
                            n_out_slot = r_count[AW-1:0];
                        end
                    end
                    usrt_pkg::CMD_REMOVE, usrt_pkg::CMD_CONTAINS: begin
                        n_state = S_SCAN;
                    end
                    usrt_pkg::CMD_TAKE: begin
                        if (r_count == '0) begin
                            n_done = 1'b1;
                        end else begin
                            n_state = S_MOD;
                        end
                    end
                    usrt_pkg::CMD_CLEAR: begin
                        n_done  = 1'b1;
                        n_count = '0;
                        n_ptr   = '0;
                        n_ok    = 1'b1;
                    end
                    default: begin
                        n_done = 1'b1;
                    end
                endcase
            end
            S_SCAN: begin
                ram_raddr = r_idx[AW-1:0];
                if (r_pend && ram_rdata == r_val) begin
                    if (r_cmd == usrt_pkg::CMD_CONTAINS) begin
                        n_ok    = 1'b1;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_slot  = prev_idx[AW-1:0];
                        n_state = S_RD_LAST;
                    end
                end else if (r_idx == r_count) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end
            end
            S_MOD: begin
                if (r_ptr >= r_count) begin
                    n_ptr = r_ptr - r_count;
                end else begin
                    n_slot  = r_ptr[AW-1:0];
                    n_state = S_RD_IDX;
                end
            end
            S_RD_IDX: begin
                ram_raddr = r_slot;
                n_state   = S_RD_LAST;
            end
            S_RD_LAST: begin
                ram_raddr = last_idx[AW-1:0];
                n_item    = ram_rdata;
                n_state   = S_WRITE;
            end
            S_WRITE: begin
                ram_we     = 1'b1;
                n_count    = last_idx;
                n_ok       = 1'b1;
                n_out_slot = r_slot;
                n_done     = 1'b1;
                n_state    = S_IDLE;
                if (r_cmd == usrt_pkg::CMD_TAKE) begin
                    n_out_item = r_item;
                    n_ptr      = r_ptr + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ptr   <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ptr   <= n_ptr;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
        r_cmd      <= n_cmd;
        r_val      <= n_val;
        r_slot     <= n_slot;
        r_item     <= n_item;
        r_ok       <= n_ok;
        r_out_item <= n_out_item;
        r_out_slot <= n_out_slot;
    end

    assign item_ext  = {{usrt_pkg::ITEM_W{1'b0}}, r_out_item};
    assign slot_ext  = {{usrt_pkg::SLOT_W{1'b0}}, r_out_slot};
    assign count_ext = {{usrt_pkg::COUNT_W{1'b0}}, r_count};

    assign busy       = (r_state != S_IDLE);
    assign o_done     = r_done;
    assign o_ok       = r_ok;
    assign o_item_out = item_ext[usrt_pkg::ITEM_W-1:0];
    assign o_slot     = slot_ext[usrt_pkg::SLOT_W-1:0];
    assign o_count    = count_ext[usrt_pkg::COUNT_W-1:0];

    `include "unordered_set_rotating_take_core_assert.svh"

    `USRT_ASSERT_IMPL(a_count_max, 1'b1, r_count <= CW'(DEPTH))
    `USRT_ASSERT_IMPL(a_ptr_max, 1'b1, r_ptr <= CW'(DEPTH))
    `USRT_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
    `USRT_ASSERT_IMPL(a_done_idle, o_done, !busy)
    `USRT_ASSERT_NEXT(a_write_one_less, r_state == S_WRITE, r_count == $past(r_count) - 1'b1)

endmodule

### tb/tb_unordered_set_rotating_take_core.sv
// ----------------------------------------------------------------------------
// tb_unordered_set_rotating_take_core
// Self-checking bench for the unordered set core. A shadow copy of the set
// predicts every result (swap-delete, first-match search, rotating take
// pointer). Stimulus runs directed corner commands, a fill-to-full and drain
// pass, then long random mixes with values biased toward stored entries.
// ----------------------------------------------------------------------------
module tb_unordered_set_rotating_take_core;

    localparam int SET_DEPTH     = 64;
    localparam int IDLE_LIMIT    = 1000;
    localparam int MIX_ITEMS     = 1200;

    // codes the core ignores
    localparam logic [usrt_pkg::CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [usrt_pkg::CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [usrt_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} t_mix_bias;

    typedef struct packed {
        logic                         ok;
        logic [usrt_pkg::ITEM_W-1:0]  item_out;
        logic [usrt_pkg::SLOT_W-1:0]  slot;
        logic [usrt_pkg::COUNT_W-1:0] count;
    } t_set_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic [usrt_pkg::CMD_W-1:0]   i_cmd = usrt_pkg::CMD_APPEND;
    logic [usrt_pkg::ITEM_W-1:0]  i_item_value = '0;
    logic                         busy;
    logic                         o_done;
    logic                         o_ok;
    logic [usrt_pkg::ITEM_W-1:0]  o_item_out;
    logic [usrt_pkg::SLOT_W-1:0]  o_slot;
    logic [usrt_pkg::COUNT_W-1:0] o_count;

    logic [usrt_pkg::ITEM_W-1:0]  entry_words [SET_DEPTH];
    int                           entry_total = 0;
    int                           take_ptr = 0;
    t_set_result                  pending_results [$];
    int                           error_count = 0;
    int                           idle_cycles = 0;
    bit                           quiet = 1'b0;

    unordered_set_rotating_take_core #(
        .DEPTH     (SET_DEPTH),
        .ITEM_BITS (usrt_pkg::ITEM_W)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_item_value (i_item_value),
        .o_done       (o_done),
        .o_ok         (o_ok),
        .o_item_out   (o_item_out),
        .o_slot       (o_slot),
        .o_count      (o_count)
    );

    always #5 i_clk = ~i_clk;

    // shadow set: updates state, returns the expected result
    function automatic t_set_result apply_set_command(
            input logic [usrt_pkg::CMD_W-1:0]  cmd,
            input logic [usrt_pkg::ITEM_W-1:0] value);
        t_set_result r;
        int hit;
        r = '0;
        hit = -1;
        if (cmd == usrt_pkg::CMD_REMOVE || cmd == usrt_pkg::CMD_CONTAINS) begin
            for (int i = 0; i < entry_total; i++) begin
                if (hit < 0 && entry_words[i] == value) hit = i;
            end
        end
        case (cmd)
            usrt_pkg::CMD_APPEND: begin
                if (entry_total < SET_DEPTH) begin
                    entry_words[entry_total] = value;
                    r.slot = entry_total[usrt_pkg::SLOT_W-1:0];
                    entry_total++;
                    r.ok = 1'b1;
                end
            end
            usrt_pkg::CMD_REMOVE: begin
                if (hit >= 0) begin
                    entry_total--;
                    entry_words[hit] = entry_words[entry_total];
                    r.slot = hit[usrt_pkg::SLOT_W-1:0];
                    r.ok = 1'b1;
                end
            end
            usrt_pkg::CMD_CONTAINS: r.ok = (hit >= 0);
            usrt_pkg::CMD_TAKE: begin
                if (entry_total != 0) begin
                    take_ptr = take_ptr % entry_total;
                    r.item_out = entry_words[take_ptr];
                    r.slot = take_ptr[usrt_pkg::SLOT_W-1:0];
                    entry_total--;
                    entry_words[take_ptr] = entry_words[entry_total];
                    take_ptr++;
                    r.ok = 1'b1;
                end
            end
            usrt_pkg::CMD_CLEAR: begin
                entry_total = 0;
                take_ptr = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.count = entry_total[usrt_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // half the picks from values already in the set (if any), some from a small pool, some anything
    function automatic logic [usrt_pkg::ITEM_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 3);
        if (sel < 2 && entry_total > 0) return entry_words[$urandom_range(0, entry_total - 1)];
        if (sel == 2) return usrt_pkg::ITEM_W'($urandom_range(0, 15));
        return usrt_pkg::ITEM_W'($urandom);
    endfunction

    function automatic logic [usrt_pkg::CMD_W-1:0] pick_ignored();
        case ($urandom_range(0, 2))
            0:       return CMD_RSVD5;
            1:       return CMD_RSVD6;
            default: return CMD_RSVD7;
        endcase
    endfunction

    function automatic logic [usrt_pkg::CMD_W-1:0] pick_cmd(input t_mix_bias bias);
        int r;
        r = $urandom_range(0, 99);
        case (bias)
            MIX_FILL: begin
                if (r < 65) return usrt_pkg::CMD_APPEND;
                if (r < 75) return usrt_pkg::CMD_REMOVE;
                if (r < 87) return usrt_pkg::CMD_CONTAINS;
                if (r < 98) return usrt_pkg::CMD_TAKE;
                return pick_ignored();
            end
            MIX_DRAIN: begin
                if (r < 20) return usrt_pkg::CMD_APPEND;
                if (r < 45) return usrt_pkg::CMD_REMOVE;
                if (r < 60) return usrt_pkg::CMD_CONTAINS;
                if (r < 96) return usrt_pkg::CMD_TAKE;
                if (r < 98) return usrt_pkg::CMD_CLEAR;
                return pick_ignored();
            end
            default: begin
                if (r < 35) return usrt_pkg::CMD_APPEND;
                if (r < 55) return usrt_pkg::CMD_REMOVE;
                if (r < 72) return usrt_pkg::CMD_CONTAINS;
                if (r < 93) return usrt_pkg::CMD_TAKE;
                if (r < 96) return usrt_pkg::CMD_CLEAR;
                return pick_ignored();
            end
        endcase
    endfunction

    task automatic issue_command(input logic [usrt_pkg::CMD_W-1:0]  cmd,
                                 input logic [usrt_pkg::ITEM_W-1:0] value);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_item_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(apply_set_command(cmd, value));
    endtask

    task automatic test_directed();
        quiet = 1'b0;
        issue_command(usrt_pkg::CMD_CLEAR, 32'h0000_0000);
        issue_command(usrt_pkg::CMD_TAKE, 32'h1234_5678);
        issue_command(usrt_pkg::CMD_REMOVE, 32'h0000_0000);
        issue_command(usrt_pkg::CMD_CONTAINS, 32'h0000_0000);
        issue_command(usrt_pkg::CMD_APPEND, 32'h0000_0000);
        issue_command(usrt_pkg::CMD_APPEND, 32'hFFFF_FFFF);
        issue_command(usrt_pkg::CMD_APPEND, 32'h0000_0000);
        issue_command(usrt_pkg::CMD_APPEND, 32'hA5A5_5A5A);
        issue_command(usrt_pkg::CMD_CONTAINS, 32'hFFFF_FFFF);
        issue_command(usrt_pkg::CMD_CONTAINS, 32'h1234_5678);
        issue_command(usrt_pkg::CMD_REMOVE, 32'h0000_0000);
        issue_command(usrt_pkg::CMD_CONTAINS, 32'h0000_0000);
        issue_command(usrt_pkg::CMD_REMOVE, 32'h5A5A_A5A5);
        issue_command(CMD_RSVD5, 32'hFFFF_FFFF);
        issue_command(usrt_pkg::CMD_TAKE, 32'h0000_0000);
        issue_command(usrt_pkg::CMD_TAKE, 32'hFFFF_FFFF);
        issue_command(usrt_pkg::CMD_TAKE, 32'h0000_0000);
        issue_command(usrt_pkg::CMD_TAKE, 32'h0000_0000);
        issue_command(CMD_RSVD6, 32'h0000_0000);
        issue_command(usrt_pkg::CMD_APPEND, 32'h55AA_55AA);
        issue_command(CMD_RSVD7, 32'h55AA_55AA);
        issue_command(usrt_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
        issue_command(usrt_pkg::CMD_APPEND, 32'hFFFF_FFFF);
        issue_command(usrt_pkg::CMD_TAKE, 32'h0000_0000);
    endtask

    // fill to capacity, append past full, then drain past empty
    task automatic test_fill_and_overflow();
        issue_command(usrt_pkg::CMD_CLEAR, usrt_pkg::ITEM_W'($urandom));
        for (int i = 0; i < SET_DEPTH + 3; i++) begin
            quiet = (i < SET_DEPTH / 2);
            issue_command(usrt_pkg::CMD_APPEND, pick_value());
        end
        issue_command(usrt_pkg::CMD_CONTAINS, entry_words[SET_DEPTH - 1]);
        issue_command(usrt_pkg::CMD_REMOVE, entry_words[SET_DEPTH - 1]);
        issue_command(usrt_pkg::CMD_APPEND, usrt_pkg::ITEM_W'($urandom));
        for (int i = 0; i < SET_DEPTH + 2; i++) begin
            quiet = (i >= SET_DEPTH / 2);
            issue_command(usrt_pkg::CMD_TAKE, usrt_pkg::ITEM_W'($urandom));
        end
        quiet = 1'b0;
    endtask

    task automatic test_random_mix();
        t_mix_bias bias;
        bias = MIX_BALANCED;
        for (int i = 0; i < MIX_ITEMS; i++) begin
            if (i % 50 == 0) begin
                bias  = t_mix_bias'($urandom_range(0, 2));
                quiet = ($urandom_range(0, 3) == 0);
            end
            issue_command(pick_cmd(bias), pick_value());
        end
        quiet = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_set_result exp_r;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result ok=%0b item=%h slot=%0d count=%0d",
                         $time, o_ok, o_item_out, o_slot, o_count);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_ok !== exp_r.ok) begin
                    $display("%0t: ok expected %0b actual %0b", $time, exp_r.ok, o_ok);
                    error_count++;
                end
                if (o_item_out !== exp_r.item_out) begin
                    $display("%0t: item_out expected %h actual %h",
                             $time, exp_r.item_out, o_item_out);
                    error_count++;
                end
                if (o_slot !== exp_r.slot) begin
                    $display("%0t: slot expected %0d actual %0d", $time, exp_r.slot, o_slot);
                    error_count++;
                end
                if (o_count !== exp_r.count) begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, exp_r.count, o_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_unordered_set_rotating_take_core: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_and_overflow();
        test_random_mix();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SET_DEPTH + 16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_unordered_set_rotating_take_core: clean");
        end else begin
            $display("tb_unordered_set_rotating_take_core: errors");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/usrt_pkg.sv
rtl/usrt_ram.sv
rtl/unordered_set_rotating_take_core.sv
tb/tb_unordered_set_rotating_take_core.sv
